// ----- rtl/mm_pkg.sv -----
package mm_pkg;

    localparam int ROW_W   = 3;
    localparam int VAL_W   = 16;
    localparam int PROD_W  = 40;
    localparam int MUL_W   = 2 * VAL_W;
    localparam int CFG_W   = 4;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

    // Load kinds.
    localparam logic KIND_A = 1'b0;
    localparam logic KIND_B = 1'b1;

    typedef struct packed {
        logic                     kind;
        logic [ROW_W-1:0]         row;
        logic [ROW_W-1:0]         col;
        logic signed [VAL_W-1:0]  value;
        logic                     last;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0]         out_row;
        logic [ROW_W-1:0]         out_col;
        logic signed [PROD_W-1:0] product;
        logic                     final_res;
    } t_out_item;

endpackage

// ----- rtl/mm_ram.sv -----
module mm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/matrix_multiply.sv -----
// Matrix multiplier C = A x B on signed Q8.8 elements, exact Q24.16 results.
// Input channel (i_valid / o_stall): each beat loads one element of A or B,
// with its row and column, into an on-chip store. Loads are taken one per
// cycle while idle. Loads with a row or column beyond the store are dropped.
// A beat marked last is stored and then starts the multiply; o_stall stays
// high until the final result element has been placed in the output register.
// Output channel (o_valid / i_stall): one beat per element of C in row-major
// order, the final one flagged by final_res. For each element the sequencer
// issues inner_dim reads from the single read port of each store; the read
// data, the product and the running sum are each registered in turn. A stall
// holds the output register and the sequencer waits before emitting the next
// element. New loads may be accepted while the final result still sits in the
// output register.
// The user must write the dimension registers via the plain write port while
// idle, unenforced by the block. Values are clamped to 1..MAX_DIM before use.
// Reset sets all dimensions to 8 and empties the pipeline; the stores are
// not cleared and must be loaded before they are read.
module matrix_multiply
    import mm_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in_item             i_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out_item            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(MAX_DIM);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_EMIT
    } t_state;

    // Turns a dimension register into the index of its last element.
    function automatic logic [IW-1:0] last_index(input logic [CFG_W-1:0] d);
        logic [IW-1:0] res;
        if (d == '0) begin
            res = '0;
        end else if (32'(d) > MAX_DIM) begin
            res = IW'(MAX_DIM - 1);
        end else begin
            res = IW'(d - 4'd1);
        end
        return res;
    endfunction

    t_state                   r_state;
    logic [CFG_W-1:0]         r_rows_a;
    logic [CFG_W-1:0]         r_inner_dim;
    logic [CFG_W-1:0]         r_cols_b;
    logic [IW-1:0]            r_m_lim;
    logic [IW-1:0]            r_k_lim;
    logic [IW-1:0]            r_n_lim;
    logic [IW-1:0]            r_i;
    logic [IW-1:0]            r_j;
    logic [IW-1:0]            r_k;
    logic                     r_issuing;
    logic                     r_rd_vld;
    logic                     r_rd_first;
    logic                     r_rd_last;
    logic                     r_mul_vld;
    logic                     r_mul_first;
    logic                     r_mul_last;
    logic signed [MUL_W-1:0]  r_prod;
    logic signed [PROD_W-1:0] r_acc;
    logic                     r_out_vld;
    t_out_item                r_out;

    logic                     in_acc;
    logic                     in_range;
    logic                     a_we;
    logic                     b_we;
    logic [AW-1:0]            waddr;
    logic [AW-1:0]            a_raddr;
    logic [AW-1:0]            b_raddr;
    logic [VAL_W-1:0]         a_rdata;
    logic [VAL_W-1:0]         b_rdata;
    logic signed [PROD_W-1:0] sum;
    logic                     out_free;
    logic                     is_final;

    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign in_range = (32'(i_in.row) < MAX_DIM) && (32'(i_in.col) < MAX_DIM);
    assign waddr    = AW'(32'(i_in.row) * MAX_DIM + 32'(i_in.col));
    assign a_we     = in_acc && in_range && (i_in.kind == KIND_A);
    assign b_we     = in_acc && in_range && (i_in.kind == KIND_B);

    // A is walked along row i, B down column j.
    assign a_raddr  = AW'(32'(r_i) * MAX_DIM + 32'(r_k));
    assign b_raddr  = AW'(32'(r_k) * MAX_DIM + 32'(r_j));

    mm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_a_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (waddr),
        .i_wdata (i_in.value),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    mm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_b_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (waddr),
        .i_wdata (i_in.value),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    assign sum      = (r_mul_first ? PROD_W'(0) : r_acc) + PROD_W'(r_prod);
    assign out_free = !r_out_vld || !i_stall;
    assign is_final = (r_i == r_m_lim) && (r_j == r_n_lim);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= DIM_RESET;
            r_inner_dim <= DIM_RESET;
            r_cols_b    <= DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROWS_A:    r_rows_a    <= i_cfg_data;
                CFG_INNER_DIM: r_inner_dim <= i_cfg_data;
                CFG_COLS_B:    r_cols_b    <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // Multiply-accumulate datapath: read data, product, running sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_mul_vld <= 1'b0;
        end else begin
            r_rd_vld  <= r_issuing;
            r_mul_vld <= r_rd_vld;
        end
        r_rd_first  <= (r_k == '0);
        r_rd_last   <= (r_k == r_k_lim);
        r_mul_first <= r_rd_first;
        r_mul_last  <= r_rd_last;
        r_prod      <= $signed(a_rdata) * $signed(b_rdata);
        if (r_mul_vld) begin
            r_acc <= sum;
        end
    end

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_issuing <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            // In the emit state the output register is handled below.
            if (r_out_vld && !i_stall && (r_state != S_EMIT)) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in.last) begin
                        r_m_lim   <= last_index(r_rows_a);
                        r_k_lim   <= last_index(r_inner_dim);
                        r_n_lim   <= last_index(r_cols_b);
                        r_i       <= '0;
                        r_j       <= '0;
                        r_k       <= '0;
                        r_issuing <= 1'b1;
                        r_state   <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (r_issuing) begin
                        if (r_k == r_k_lim) begin
                            r_issuing <= 1'b0;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                    if (r_mul_vld && r_mul_last) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_vld         <= 1'b1;
                        r_out.out_row     <= ROW_W'(r_i);
                        r_out.out_col     <= ROW_W'(r_j);
                        r_out.product     <= r_acc;
                        r_out.final_res   <= is_final;
                        if (is_final) begin
                            r_state <= S_IDLE;
                        end else begin
                            if (r_j == r_n_lim) begin
                                r_j <= '0;
                                r_i <= r_i + 1'b1;
                            end else begin
                                r_j <= r_j + 1'b1;
                            end
                            r_k       <= '0;
                            r_issuing <= 1'b1;
                            r_state   <= S_MAC;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_out_vld;
    assign o_out   = r_out;

    // The pipeline has drained by the time an element is emitted.
    a_emit_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (!r_rd_vld && !r_mul_vld))
        else $error("result emitted while products still in flight");

    // The last product of an element always moves the sequencer to emit.
    a_last_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mul_vld && r_mul_last) |=> (r_state == S_EMIT))
        else $error("final product did not lead to emit");

    // The stores are never written while a multiply reads them.
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (!a_we && !b_we))
        else $error("store written during multiply");

    // Reads are issued only inside the multiply-accumulate phase.
    a_issue_in_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issuing |-> (r_state == S_MAC))
        else $error("read issued outside accumulate phase");

endmodule
